FILE: sv/dgpb_pkg.sv
`timescale 1ns / 1ps
package dgpb_pkg;

  typedef enum logic [1:0] {
    FUSE_SOFT   = 2'd0,
    FUSE_HARD   = 2'd1,
    FUSE_TARGET = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_DIV,
    ST_FIN
  } state_t;

  // mode_select codes
  localparam logic [1:0] SEL_AUTO   = 2'd0;
  localparam logic [1:0] SEL_SOFT   = 2'd1;
  localparam logic [1:0] SEL_HARD   = 2'd2;
  localparam logic [1:0] SEL_TARGET = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_MODE_SELECT       = 3'd0;
  localparam logic [2:0] CFG_TARGET_PRESSURE   = 3'd1;
  localparam logic [2:0] CFG_LOW_FULL_SCALE    = 3'd2;
  localparam logic [2:0] CFG_BLEND_START       = 3'd3;
  localparam logic [2:0] CFG_BLEND_END         = 3'd4;
  localparam logic [2:0] CFG_SWITCH_UP_LEVEL   = 3'd5;
  localparam logic [2:0] CFG_SWITCH_DOWN_LEVEL = 3'd6;
  localparam logic [2:0] CFG_TARGET_WINDOW     = 3'd7;

  localparam logic [15:0] RST_LOW_FULL_SCALE    = 16'd655;
  localparam logic [15:0] RST_BLEND_START       = 16'd524;
  localparam logic [15:0] RST_BLEND_END         = 16'd655;
  localparam logic [15:0] RST_SWITCH_UP_LEVEL   = 16'd623;
  localparam logic [15:0] RST_SWITCH_DOWN_LEVEL = 16'd557;
  localparam logic [15:0] RST_TARGET_WINDOW     = 16'd33;

  localparam logic [15:0] CONSISTENCY_LIMIT = 16'd3277;
  localparam logic [15:0] TARGET_LOW_LIMIT  = 16'd6554;
  localparam logic [15:0] ACTUAL_HIGH_LIMIT = 16'd6554;

  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic sum;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } stat_t;

endpackage

FILE: sv/dgpb_in_if.sv
`timescale 1ns / 1ps
interface dgpb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] low_reading;
  logic [15:0] high_reading;

  modport source (output valid, low_reading, high_reading, input ready);
  modport sink (input valid, low_reading, high_reading, output ready);
endinterface

FILE: sv/dgpb_out_if.sv
`timescale 1ns / 1ps
interface dgpb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fused_pressure;
  logic [1:0]  mode_used;
  logic        low_selected;

  modport source (output valid, fused_pressure, mode_used, low_selected, input ready);
  modport sink (input valid, fused_pressure, mode_used, low_selected, output ready);
endinterface

FILE: sv/dgpb_datapath.sv
`timescale 1ns / 1ps
module dgpb_datapath (
  input  logic           clk,
  input  logic           rst,
  input  dgpb_pkg::cmd_t cmd,
  output dgpb_pkg::stat_t stat,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic [15:0]    low_reading_in,
  input  logic [15:0]    high_reading_in,
  output logic [15:0]    fused_pressure,
  output logic [1:0]     mode_used,
  output logic           low_selected
);

  logic [1:0]  mode_select;
  logic [15:0] target_pressure;
  logic [15:0] low_full_scale;
  logic [15:0] blend_start;
  logic [15:0] blend_end;
  logic [15:0] switch_up_level;
  logic [15:0] switch_down_level;
  logic [15:0] target_window;

  logic use_low_gauge;
  logic gauges_agree;

  logic [15:0] lo;
  logic [15:0] hi;
  logic [15:0] res;
  dgpb_pkg::mode_t mode;
  logic        need_div;
  logic [31:0] prod_lo;
  logic [31:0] prod_hi;
  logic [15:0] den;
  logic [16:0] rem;
  logic [15:0] quot;

  // evaluation logic
  logic [15:0] tp_diff;
  logic [15:0] gap;
  logic [31:0] agree_rhs;
  logic        in_window;
  logic        agree_next;
  logic        use_low_next;
  logic        target_hit;
  dgpb_pkg::mode_t mode_next;
  logic        upd_agree;
  logic [15:0] res_next;
  logic        need_div_next;
  logic [32:0] num_sum;
  logic [16:0] trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_select       <= dgpb_pkg::SEL_AUTO;
      target_pressure   <= '0;
      low_full_scale    <= dgpb_pkg::RST_LOW_FULL_SCALE;
      blend_start       <= dgpb_pkg::RST_BLEND_START;
      blend_end         <= dgpb_pkg::RST_BLEND_END;
      switch_up_level   <= dgpb_pkg::RST_SWITCH_UP_LEVEL;
      switch_down_level <= dgpb_pkg::RST_SWITCH_DOWN_LEVEL;
      target_window     <= dgpb_pkg::RST_TARGET_WINDOW;
    end else if (cfg_we) begin
      case (cfg_index)
        dgpb_pkg::CFG_MODE_SELECT:       mode_select       <= cfg_data[1:0];
        dgpb_pkg::CFG_TARGET_PRESSURE:   target_pressure   <= cfg_data;
        dgpb_pkg::CFG_LOW_FULL_SCALE:    low_full_scale    <= cfg_data;
        dgpb_pkg::CFG_BLEND_START:       blend_start       <= cfg_data;
        dgpb_pkg::CFG_BLEND_END:         blend_end         <= cfg_data;
        dgpb_pkg::CFG_SWITCH_UP_LEVEL:   switch_up_level   <= cfg_data;
        dgpb_pkg::CFG_SWITCH_DOWN_LEVEL: switch_down_level <= cfg_data;
        dgpb_pkg::CFG_TARGET_WINDOW:     target_window     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tp_diff    = (lo >= target_pressure) ? lo - target_pressure : target_pressure - lo;
    gap        = (lo >= hi) ? lo - hi : hi - lo;
    agree_rhs  = 32'(dgpb_pkg::CONSISTENCY_LIMIT) * 32'(lo);
    in_window  = (lo >= blend_start) && (lo <= blend_end);
    target_hit = (target_pressure != 16'd0) && (tp_diff < target_window);

    if (!in_window) begin
      agree_next = gauges_agree;
    end else if (lo == 16'd0) begin
      agree_next = 1'b0;
    end else begin
      agree_next = ({gap, 16'd0} <= agree_rhs);
    end

    upd_agree = 1'b0;
    case (mode_select)
      dgpb_pkg::SEL_AUTO: begin
        if (target_hit) begin
          mode_next = dgpb_pkg::FUSE_TARGET;
        end else begin
          upd_agree = 1'b1;
          mode_next = agree_next ? dgpb_pkg::FUSE_SOFT : dgpb_pkg::FUSE_HARD;
        end
      end
      dgpb_pkg::SEL_SOFT: mode_next = dgpb_pkg::FUSE_SOFT;
      dgpb_pkg::SEL_HARD: mode_next = dgpb_pkg::FUSE_HARD;
      default:            mode_next = dgpb_pkg::FUSE_TARGET;
    endcase

    // up test wins when the levels overlap
    if (lo >= switch_up_level) begin
      use_low_next = 1'b0;
    end else if (lo <= switch_down_level) begin
      use_low_next = 1'b1;
    end else begin
      use_low_next = use_low_gauge;
    end

    need_div_next = 1'b0;
    case (mode_next)
      dgpb_pkg::FUSE_SOFT: begin
        if (lo <= blend_start) begin
          res_next = lo;
        end else if (lo >= blend_end) begin
          res_next = hi;
        end else begin
          res_next      = lo;
          need_div_next = 1'b1;
        end
      end
      dgpb_pkg::FUSE_HARD: res_next = use_low_next ? lo : hi;
      default: begin
        if (target_pressure < dgpb_pkg::TARGET_LOW_LIMIT && hi > dgpb_pkg::ACTUAL_HIGH_LIMIT) begin
          res_next = hi;
        end else begin
          res_next = (target_pressure < low_full_scale) ? lo : hi;
        end
      end
    endcase

    // numerator plus half divisor for round-half-up
    num_sum = {1'b0, prod_lo} + {1'b0, prod_hi} + {18'd0, den[15:1]};
    trial   = {rem[15:0], quot[15]};
  end

  assign stat.need_div = need_div_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_low_gauge <= 1'b1;
      gauges_agree  <= 1'b1;
    end else if (cmd.eval) begin
      if (upd_agree) begin
        gauges_agree <= agree_next;
      end
      if (mode_next == dgpb_pkg::FUSE_HARD) begin
        use_low_gauge <= use_low_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      lo <= low_reading_in;
      hi <= high_reading_in;
    end
    if (cmd.eval) begin
      mode     <= mode_next;
      res      <= res_next;
      need_div <= need_div_next;
      prod_lo  <= 32'(lo) * 32'(blend_end - lo);
      prod_hi  <= 32'(hi) * 32'(lo - blend_start);
      den      <= blend_end - blend_start;
    end
    if (cmd.sum) begin
      // quotient fits 16 bits, so the upper half is already below den
      rem  <= num_sum[32:16];
      quot <= num_sum[15:0];
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, den}) begin
        rem  <= trial - {1'b0, den};
        quot <= {quot[14:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[14:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      fused_pressure <= need_div ? quot : res;
      mode_used      <= mode;
      low_selected   <= use_low_gauge;
    end
  end

endmodule

FILE: sv/dgpb_ctrl.sv
`timescale 1ns / 1ps
module dgpb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  dgpb_pkg::stat_t stat,
  output dgpb_pkg::cmd_t  cmd
);

  dgpb_pkg::state_t state;
  dgpb_pkg::state_t state_next;
  logic [dgpb_pkg::DIV_CNT_W-1:0] cnt;
  logic [dgpb_pkg::DIV_CNT_W-1:0] cnt_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dgpb_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      dgpb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = dgpb_pkg::ST_EVAL;
        end
      end
      dgpb_pkg::ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.need_div ? dgpb_pkg::ST_SUM : dgpb_pkg::ST_FIN;
      end
      dgpb_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        cnt_next   = '0;
        state_next = dgpb_pkg::ST_DIV;
      end
      dgpb_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == dgpb_pkg::DIV_CNT_W'(dgpb_pkg::DIV_STEPS - 1)) begin
          state_next = dgpb_pkg::ST_FIN;
        end
      end
      dgpb_pkg::ST_FIN: begin
        // output register must be free or emptying this cycle
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = dgpb_pkg::ST_IDLE;
        end
      end
      default: state_next = dgpb_pkg::ST_IDLE;
    endcase

    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    (state == dgpb_pkg::ST_IDLE && in_valid) |=> (state == dgpb_pkg::ST_EVAL))
    else $error("accepted request did not start evaluation");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote an untaken result");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (state == dgpb_pkg::ST_SUM) |=> (state == dgpb_pkg::ST_DIV && cnt == '0))
    else $error("division did not start from zero");

endmodule

FILE: sv/dual_gauge_pressure_blend.sv
`timescale 1ns / 1ps
// Fuses a low-range and a high-range gauge reading into one Q0.16 pressure,
// one result per request. After its request is accepted, a hard, target or
// out-of-window soft pick passes through the evaluate and finish states into
// the output register; a soft blend inside its window passes through evaluate,
// sum, the divide steps and finish, where a restoring divider produces one
// quotient bit per cycle into a 16-bit quotient. The block accepts again the
// cycle after the load. The next request is accepted once the previous one
// has reached the output register, even if that result has not been taken
// yet; it then waits in its last step until the output frees.
// Registers may be written only while the block is idle; a write takes effect
// on the next request.
module dual_gauge_pressure_blend (
  input  logic        clk,
  input  logic        rst,
  dgpb_in_if.sink     sample,
  dgpb_out_if.source  result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dgpb_pkg::cmd_t  cmd;
  dgpb_pkg::stat_t stat;

  dgpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dgpb_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .low_reading_in  (sample.low_reading),
    .high_reading_in (sample.high_reading),
    .fused_pressure  (result.fused_pressure),
    .mode_used       (result.mode_used),
    .low_selected    (result.low_selected)
  );

endmodule

FILE: tb/dual_gauge_pressure_blend_tb.sv
`timescale 1ns / 1ps
module dual_gauge_pressure_blend_tb;

  typedef struct packed {
    logic [15:0]     fused;
    dgpb_pkg::mode_t mode;
    logic            low_sel;
  } fusion_t;

  // Holds its own copy of the registers and the gauge state, and the fused
  // readings still owed by the block, oldest first.
  class fusion_scoreboard;
    logic [1:0]  sel;
    logic [15:0] tgt, lfs, bstart, bend, up_lvl, down_lvl, window;
    bit          use_low, agree;
    fusion_t     owed_q[$];
    int          errors;

    function new();
      sel      = dgpb_pkg::SEL_AUTO;
      tgt      = '0;
      lfs      = dgpb_pkg::RST_LOW_FULL_SCALE;
      bstart   = dgpb_pkg::RST_BLEND_START;
      bend     = dgpb_pkg::RST_BLEND_END;
      up_lvl   = dgpb_pkg::RST_SWITCH_UP_LEVEL;
      down_lvl = dgpb_pkg::RST_SWITCH_DOWN_LEVEL;
      window   = dgpb_pkg::RST_TARGET_WINDOW;
      use_low  = 1'b1;
      agree    = 1'b1;
      errors   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        dgpb_pkg::CFG_MODE_SELECT:       sel = val[1:0];
        dgpb_pkg::CFG_TARGET_PRESSURE:   tgt = val;
        dgpb_pkg::CFG_LOW_FULL_SCALE:    lfs = val;
        dgpb_pkg::CFG_BLEND_START:       bstart = val;
        dgpb_pkg::CFG_BLEND_END:         bend = val;
        dgpb_pkg::CFG_SWITCH_UP_LEVEL:   up_lvl = val;
        dgpb_pkg::CFG_SWITCH_DOWN_LEVEL: down_lvl = val;
        dgpb_pkg::CFG_TARGET_WINDOW:     window = val;
        default: ;
      endcase
    endfunction

    function logic [15:0] gap(logic [15:0] a, logic [15:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function logic [15:0] blend(logic [15:0] lo, logic [15:0] hi);
      logic [63:0] num, den;
      if (lo <= bstart) return lo;
      if (lo >= bend) return hi;
      den = 64'(bend) - 64'(bstart);
      num = 64'(lo) * (64'(bend) - 64'(lo)) + 64'(hi) * (64'(lo) - 64'(bstart));
      // round to nearest, ties up
      return 16'((num + den / 2) / den);
    endfunction

    function void note_request(logic [15:0] lo, logic [15:0] hi);
      fusion_t     r;
      logic [47:0] lhs, rhs;
      if (sel == dgpb_pkg::SEL_AUTO) begin
        if (tgt != 0 && gap(lo, tgt) < window) begin
          r.mode = dgpb_pkg::FUSE_TARGET;
        end else begin
          // agreement is sticky outside the blend window
          if (lo >= bstart && lo <= bend) begin
            lhs = 48'(gap(lo, hi)) << 16;
            rhs = 48'(dgpb_pkg::CONSISTENCY_LIMIT) * 48'(lo);
            agree = (lo != 0) && (lhs <= rhs);
          end
          r.mode = agree ? dgpb_pkg::FUSE_SOFT : dgpb_pkg::FUSE_HARD;
        end
      end else if (sel == dgpb_pkg::SEL_SOFT) begin
        r.mode = dgpb_pkg::FUSE_SOFT;
      end else if (sel == dgpb_pkg::SEL_HARD) begin
        r.mode = dgpb_pkg::FUSE_HARD;
      end else begin
        r.mode = dgpb_pkg::FUSE_TARGET;
      end

      case (r.mode)
        dgpb_pkg::FUSE_SOFT: r.fused = blend(lo, hi);
        dgpb_pkg::FUSE_HARD: begin
          if (lo >= up_lvl) use_low = 1'b0;
          else if (lo <= down_lvl) use_low = 1'b1;
          r.fused = use_low ? lo : hi;
        end
        default: begin
          if (tgt < dgpb_pkg::TARGET_LOW_LIMIT && hi > dgpb_pkg::ACTUAL_HIGH_LIMIT)
            r.fused = hi;
          else r.fused = (tgt < lfs) ? lo : hi;
        end
      endcase
      r.low_sel = use_low;
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [15:0] fused, logic [1:0] mode, logic low_sel);
      fusion_t e;
      if (owed_q.size() == 0) begin
        $error("fused_pressure: result %0d arrived with no request pending", fused);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (fused !== e.fused) begin
        $error("fused_pressure: expected %0d, actual %0d", e.fused, fused);
        errors++;
      end
      if (mode !== e.mode) begin
        $error("mode_used: expected %0d, actual %0d", e.mode, mode);
        errors++;
      end
      if (low_sel !== e.low_sel) begin
        $error("low_selected: expected %0d, actual %0d", e.low_sel, low_sel);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  dgpb_in_if  in_ch ();
  dgpb_out_if out_ch ();

  dual_gauge_pressure_blend dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (in_ch),
    .result    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fusion_scoreboard sb = new();

  int send_idle = 10;
  int recv_idle = 86;
  int sent = 0;
  int hold_left = 0;
  bit long_hold_req = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: check, then pick next ready
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.fused_pressure, out_ch.mode_used, out_ch.low_selected);
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_request(input logic [15:0] lo, input logic [15:0] hi);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.low_reading  <= lo;
    in_ch.high_reading <= hi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(lo, hi);
    sent++;
    if (sent == 200) begin
      send_idle = 86;
      recv_idle = 10;
    end else if (sent == 400) begin
      send_idle = 0;
      recv_idle = 0;
      long_hold_req = 1;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // drain all owed results, then rewrite every register
  task automatic reconfigure(input logic [1:0] sel, input logic [15:0] tgt,
                             input logic [15:0] lfs, input logic [15:0] bs,
                             input logic [15:0] be, input logic [15:0] up,
                             input logic [15:0] dn, input logic [15:0] win);
    in_ch.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    write_reg(dgpb_pkg::CFG_MODE_SELECT, 16'(sel));
    write_reg(dgpb_pkg::CFG_TARGET_PRESSURE, tgt);
    write_reg(dgpb_pkg::CFG_LOW_FULL_SCALE, lfs);
    write_reg(dgpb_pkg::CFG_BLEND_START, bs);
    write_reg(dgpb_pkg::CFG_BLEND_END, be);
    write_reg(dgpb_pkg::CFG_SWITCH_UP_LEVEL, up);
    write_reg(dgpb_pkg::CFG_SWITCH_DOWN_LEVEL, dn);
    write_reg(dgpb_pkg::CFG_TARGET_WINDOW, win);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] near(int center, int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // low readings cluster on the thresholds of the current setting
  function automatic logic [15:0] pick_low();
    int a, b;
    a = (sb.bstart < sb.bend) ? sb.bstart : sb.bend;
    b = (sb.bstart < sb.bend) ? sb.bend : sb.bstart;
    a = (a < 20) ? 0 : a - 20;
    b = (b > 65515) ? 65535 : b + 20;
    case ($urandom_range(9))
      0, 1, 2, 3: return 16'($urandom_range(b, a));
      4:          return near($urandom_range(1) ? sb.up_lvl : sb.down_lvl, 12);
      5:          return near(sb.tgt, int'(sb.window) + 8);
      6:          return 16'($urandom);
      default:    return near($urandom_range(1) ? 0 : 65535, 2);
    endcase
  endfunction

  function automatic logic [15:0] pick_high(logic [15:0] lo);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return near(lo, lo / 16 + 2);
      6, 7:             return 16'($urandom);
      8:                return near($urandom_range(1) ? 0 : 65535, 2);
      default:          return near(dgpb_pkg::ACTUAL_HIGH_LIMIT, 3);
    endcase
  endfunction

  initial begin
    logic [15:0] lo, hi, bs;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= dgpb_pkg::CFG_MODE_SELECT;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.low_reading   <= '0;
    in_ch.high_reading  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // auto from defaults: window edges, agreement lost and regained, hysteresis
    send_request(16'd0, 16'd0);
    send_request(16'd65535, 16'd65535);
    send_request(16'd524, 16'd530);
    send_request(16'd600, 16'd610);
    send_request(16'd600, 16'd700);
    send_request(16'd640, 16'd3000);
    send_request(16'd590, 16'd20000);
    send_request(16'd550, 16'd9000);
    send_request(16'd100, 16'd9000);
    send_request(16'd630, 16'd640);

    // auto near a low setpoint
    reconfigure(dgpb_pkg::SEL_AUTO, 16'd600, 16'd655, 16'd524, 16'd655, 16'd623, 16'd557,
                16'd33);
    send_request(16'd610, 16'd5000);
    send_request(16'd590, 16'd100);
    send_request(16'd633, 16'd0);

    // forced target with setpoint at full scale
    reconfigure(dgpb_pkg::SEL_TARGET, 16'd65535, 16'd65535, 16'd524, 16'd655, 16'd623,
                16'd557, 16'd33);
    send_request(16'd1, 16'd2);
    send_request(16'd65535, 16'd0);

    // forced soft, inverted window
    reconfigure(dgpb_pkg::SEL_SOFT, 16'd0, 16'd655, 16'd1000, 16'd200, 16'd623, 16'd557,
                16'd33);
    send_request(16'd500, 16'd9);
    send_request(16'd2000, 16'd7);

    // forced soft, two-wide window: exact half rounds up
    reconfigure(dgpb_pkg::SEL_SOFT, 16'd0, 16'd655, 16'd0, 16'd2, 16'd623, 16'd557, 16'd33);
    send_request(16'd1, 16'd0);

    // forced hard, overlapping levels: up test wins
    reconfigure(dgpb_pkg::SEL_HARD, 16'd0, 16'd655, 16'd524, 16'd655, 16'd100, 16'd200,
                16'd33);
    send_request(16'd150, 16'd4000);
    send_request(16'd50, 16'd4000);

    // auto with zero low reading inside the window: disagreement
    reconfigure(dgpb_pkg::SEL_AUTO, 16'd0, 16'd655, 16'd0, 16'd100, 16'd623, 16'd557, 16'd33);
    send_request(16'd0, 16'd0);
    send_request(16'd40, 16'd41);

    for (int ph = 0; ph < 9; ph++) begin
      bs = 16'($urandom_range(65000));
      case (ph)
        0: reconfigure(dgpb_pkg::SEL_AUTO, 16'd0, dgpb_pkg::RST_LOW_FULL_SCALE,
                       dgpb_pkg::RST_BLEND_START, dgpb_pkg::RST_BLEND_END,
                       dgpb_pkg::RST_SWITCH_UP_LEVEL, dgpb_pkg::RST_SWITCH_DOWN_LEVEL,
                       dgpb_pkg::RST_TARGET_WINDOW);
        1: reconfigure(dgpb_pkg::SEL_AUTO, 16'($urandom_range(900, 300)),
                       dgpb_pkg::RST_LOW_FULL_SCALE, dgpb_pkg::RST_BLEND_START,
                       dgpb_pkg::RST_BLEND_END, dgpb_pkg::RST_SWITCH_UP_LEVEL,
                       dgpb_pkg::RST_SWITCH_DOWN_LEVEL, dgpb_pkg::RST_TARGET_WINDOW);
        2: reconfigure(dgpb_pkg::SEL_AUTO, 16'($urandom), 16'($urandom), bs,
                       bs + 16'($urandom_range(535, 1)), bs + 16'($urandom_range(500)),
                       bs + 16'($urandom_range(500)), 16'($urandom_range(2000)));
        3: reconfigure(dgpb_pkg::SEL_SOFT, 16'($urandom), 16'($urandom), 16'd0, 16'd65535,
                       16'($urandom), 16'($urandom), 16'($urandom));
        4: reconfigure(dgpb_pkg::SEL_HARD, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        5: reconfigure(dgpb_pkg::SEL_TARGET, 16'($urandom_range(13000)),
                       16'($urandom_range(13000)), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom));
        6: reconfigure(dgpb_pkg::SEL_AUTO, 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        7: reconfigure(dgpb_pkg::SEL_AUTO, 16'd65535, 16'd0, 16'd65535, 16'd65535,
                       16'd65535, 16'd65535, 16'd65535);
        default: reconfigure(dgpb_pkg::SEL_AUTO, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                             16'd0);
      endcase
      repeat (67) begin
        lo = pick_low();
        hi = pick_high(lo);
        send_request(lo, hi);
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

FILE: sim.f
sv/dgpb_pkg.sv
sv/dgpb_in_if.sv
sv/dgpb_out_if.sv
sv/dgpb_datapath.sv
sv/dgpb_ctrl.sv
sv/dual_gauge_pressure_blend.sv
tb/dual_gauge_pressure_blend_tb.sv
